// ===== hw/rtl/pemdf_pkg.sv =====
// Shared types, constants and helper functions for the PEM base64 deframer.
// No dependencies; used by every module of the block.
package pemdf_pkg;

  localparam int LINE_MAX_DEF = 80;
  localparam int LL_W         = 7;
  localparam int MAX_GROUPS   = 20;
  localparam int GRP_W        = 5;
  localparam int BEGIN_LEN    = 27;
  localparam int END_LEN      = 25;

  localparam logic [8*BEGIN_LEN-1:0] BEGIN_MARK = "-----BEGIN CERTIFICATE-----";
  localparam logic [8*END_LEN-1:0]   END_MARK   = "-----END CERTIFICATE-----";

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_PAD = 8'h3D;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  typedef struct packed {
    logic            buf_sel;
    logic [LL_W-1:0] len;
    logic            is_begin;
    logic            is_end;
    logic            eot;
  } desc_t;

  function automatic logic [7:0] begin_char(input logic [4:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < BEGIN_LEN) begin
      c = BEGIN_MARK[8*(BEGIN_LEN-1-int'(idx)) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] end_char(input logic [4:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < END_LEN) begin
      c = END_MARK[8*(END_LEN-1-int'(idx)) +: 8];
    end
    return c;
  endfunction

  function automatic logic [5:0] sextet(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 6'd62;
    end else if (c == 8'h2F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/pemdf_line_buf.sv =====
// Double line buffer: two lines of characters, one write and one read port.
// Depends on pemdf_pkg for the default line length; read data is registered.
module pemdf_line_buf #(
  parameter int LINE_MAX = pemdf_pkg::LINE_MAX_DEF,
  localparam int DEPTH  = 2 * LINE_MAX,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pemdf_desc_fifo.sv =====
// Two-entry queue of closed-line descriptors between front and back.
// Depends on pemdf_pkg for desc_t.
module pemdf_desc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pemdf_pkg::desc_t desc_i,
  output logic             full_o,
  output logic             valid_o,
  output pemdf_pkg::desc_t head_o,
  input  logic             pop_i
);

  pemdf_pkg::desc_t ent_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rp_q];

endmodule

// ===== hw/rtl/pemdf_front.sv =====
// Front part: accepts characters, fills the line buffer, tracks marker prefixes
// and pushes one descriptor per closed line. Depends on pemdf_pkg.
module pemdf_front #(
  parameter int LINE_MAX = pemdf_pkg::LINE_MAX_DEF,
  localparam int ADDR_W = $clog2(2 * LINE_MAX)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tlast,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [7:0]        wdata_o,
  output logic              push_o,
  output pemdf_pkg::desc_t  desc_o,
  input  logic              full_i
);

  localparam int LL_W = pemdf_pkg::LL_W;

  logic [LL_W-1:0] pos_q, pos_d, ll;
  logic [7:0]      last_q, last_d;
  logic            bm_q, bm_d, em_q, em_d;
  logic            wbuf_q;
  logic            acc, is_nl, store, close;

  assign s_axis_tready = !full_i;

  always_comb begin
    acc   = s_axis_tvalid && s_axis_tready;
    is_nl = (s_axis_tdata == pemdf_pkg::CH_NL);
    store = acc && !is_nl && (pos_q < LL_W'(LINE_MAX));
    close = acc && (is_nl || s_axis_tlast);
    pos_d  = store ? pos_q + LL_W'(1) : pos_q;
    last_d = store ? s_axis_tdata : last_q;
    bm_d = bm_q;
    em_d = em_q;
    if (store && pos_q < LL_W'(pemdf_pkg::BEGIN_LEN) &&
        s_axis_tdata != pemdf_pkg::begin_char(pos_q[4:0])) begin
      bm_d = 1'b0;
    end
    if (store && pos_q < LL_W'(pemdf_pkg::END_LEN) &&
        s_axis_tdata != pemdf_pkg::end_char(pos_q[4:0])) begin
      em_d = 1'b0;
    end
    ll = (pos_d != '0 && last_d == pemdf_pkg::CH_CR) ? pos_d - LL_W'(1) : pos_d;
    desc_o.buf_sel  = wbuf_q;
    desc_o.len      = ll;
    desc_o.is_begin = bm_d && (ll >= LL_W'(pemdf_pkg::BEGIN_LEN));
    desc_o.is_end   = em_d && (ll >= LL_W'(pemdf_pkg::END_LEN));
    desc_o.eot      = s_axis_tlast;
  end

  assign push_o  = close;
  assign we_o    = store;
  assign wdata_o = s_axis_tdata;
  assign waddr_o = wbuf_q ? ADDR_W'(LINE_MAX) + ADDR_W'(pos_q) : ADDR_W'(pos_q);

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bm_q   <= 1'b1;
      em_q   <= 1'b1;
      wbuf_q <= 1'b0;
    end else if (close) begin
      pos_q  <= '0;
      bm_q   <= 1'b1;
      em_q   <= 1'b1;
      wbuf_q <= ~wbuf_q;
    end else begin
      pos_q <= pos_d;
      bm_q  <= bm_d;
      em_q  <= em_d;
    end
  end

endmodule

// ===== hw/rtl/pemdf_back.sv =====
// Back part: certificate state, group-wise base64 decode from the line buffer,
// and the output register. Depends on pemdf_pkg.
module pemdf_back #(
  parameter int LINE_MAX = pemdf_pkg::LINE_MAX_DEF,
  localparam int ADDR_W = $clog2(2 * LINE_MAX)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  pemdf_pkg::desc_t  q_head_i,
  output logic              q_pop_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic [7:0]        rdata_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // data_byte
  output logic [1:0]        m_axis_tuser,  // kind
  output logic              m_axis_tlast
);

  localparam int LL_W  = pemdf_pkg::LL_W;
  localparam int GRP_W = pemdf_pkg::GRP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             inside_q, inside_d, has_q, has_d;
  logic [GRP_W-1:0] g_q, g_d, ng_q, ng_d, ngrp;
  logic [2:0]       k_q, k_d;
  logic [1:0]       e_q, e_d, e_next;
  logic             rv_q;
  logic [1:0]       rk_q;
  logic [5:0]       sx_q [4];
  logic             pad2_q, pad3_q;
  logic             ov_q, ov_d;
  logic [1:0]       okind_q, okind_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             out_free, has_next, last_grp;
  logic [7:0]       grp_raw, bsel;
  logic [GRP_W+1:0] off;

  always_comb begin
    grp_raw = 8'(q_head_i.len[LL_W-1:2]);
    ngrp = (grp_raw > 8'(pemdf_pkg::MAX_GROUPS)) ? GRP_W'(pemdf_pkg::MAX_GROUPS)
                                                 : GRP_W'(grp_raw);
    off = {g_q, k_q[1:0]};
    raddr_o = q_head_i.buf_sel ? ADDR_W'(LINE_MAX) + ADDR_W'(off) : ADDR_W'(off);
    case (e_q)
      2'd0:    bsel = {sx_q[0], sx_q[1][5:4]};
      2'd1:    bsel = {sx_q[1][3:0], sx_q[2][5:2]};
      default: bsel = {sx_q[2][1:0], sx_q[3]};
    endcase
    has_next = (e_q == 2'd0) ? (!pad2_q || !pad3_q) : (e_q == 2'd1) ? !pad3_q : 1'b0;
    e_next   = (e_q == 2'd0 && !pad2_q) ? 2'd1 : 2'd2;
    last_grp = (g_q == ng_q - GRP_W'(1));
    out_free = !ov_q || m_axis_tready;
  end

  always_comb begin
    state_d  = state_q;
    inside_d = inside_q;
    has_d    = has_q;
    g_d      = g_q;
    ng_d     = ng_q;
    k_d      = k_q;
    e_d      = e_q;
    q_pop_o  = 1'b0;
    re_o     = 1'b0;
    ov_d     = ov_q && !m_axis_tready;
    okind_d  = okind_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_head_i.is_begin) begin
            if (inside_q && has_q) begin
              ov_d = 1'b1; okind_d = pemdf_pkg::KIND_DISCARD; obyte_d = 8'h00; olast_d = 1'b1;
            end
            inside_d = !q_head_i.eot;
            has_d    = 1'b0;
          end else if (inside_q && q_head_i.is_end) begin
            if (has_q) begin
              ov_d = 1'b1; okind_d = pemdf_pkg::KIND_DONE; obyte_d = 8'h00; olast_d = 1'b1;
            end
            inside_d = 1'b0;
            has_d    = 1'b0;
          end else if (inside_q && q_head_i.len != '0) begin
            if (q_head_i.eot) begin
              if (ngrp != '0 || has_q) begin
                ov_d = 1'b1; okind_d = pemdf_pkg::KIND_DISCARD; obyte_d = 8'h00;
                olast_d = 1'b1;
              end
              inside_d = 1'b0;
              has_d    = 1'b0;
            end else if (ngrp != '0) begin
              q_pop_o = 1'b0;
              g_d     = '0;
              ng_d    = ngrp;
              k_d     = 3'd0;
              state_d = S_READ;
            end
          end else if (q_head_i.eot) begin
            if (inside_q && has_q) begin
              ov_d = 1'b1; okind_d = pemdf_pkg::KIND_DISCARD; obyte_d = 8'h00; olast_d = 1'b1;
            end
            inside_d = 1'b0;
            has_d    = 1'b0;
          end
        end
      end
      S_READ: begin
        if (k_q != 3'd4) begin
          re_o = 1'b1;
          k_d  = k_q + 3'd1;
        end
        if (rv_q && rk_q == 2'd3) begin
          e_d     = 2'd0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = pemdf_pkg::KIND_BYTE;
          obyte_d = bsel;
          olast_d = last_grp && !has_next;
          if (has_next) begin
            e_d = e_next;
          end else begin
            has_d = 1'b1;
            if (last_grp) begin
              q_pop_o = 1'b1;
              state_d = S_IDLE;
            end else begin
              g_d     = g_q + GRP_W'(1);
              k_d     = 3'd0;
              state_d = S_READ;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    g_q     <= g_d;
    ng_q    <= ng_d;
    e_q     <= e_d;
    rk_q    <= k_q[1:0];
    okind_q <= okind_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    if (rv_q) begin
      sx_q[rk_q] <= pemdf_pkg::sextet(rdata_i);
      if (rk_q == 2'd2) begin
        pad2_q <= (rdata_i == pemdf_pkg::CH_PAD);
      end
      if (rk_q == 2'd3) begin
        pad3_q <= (rdata_i == pemdf_pkg::CH_PAD);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      inside_q <= 1'b0;
      has_q    <= 1'b0;
      k_q      <= 3'd0;
      rv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      inside_q <= inside_d;
      has_q    <= has_d;
      k_q      <= k_d;
      rv_q     <= re_o;
      ov_q     <= ov_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tlast  = olast_q;

  a_busy_has_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> q_valid_i)
    else $error("decode running without a queued line");

  a_decode_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> inside_q)
    else $error("bytes decoded outside a certificate");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q != pemdf_pkg::KIND_BYTE) |-> (obyte_q == 8'h00))
    else $error("marker item carries nonzero data");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && rv_q && rk_q == 2'd3) |=> (state_q == S_EMIT))
    else $error("group read did not move to emit");

endmodule

// ===== hw/rtl/pem_certificate_base64_deframer.sv =====
// A closing character queues a line descriptor; the back part takes it from the queue and
// emits any marker item through its output register. For a data line, each group of four
// characters is read from the line buffer and then gives one output item per decoded byte.
// Input takes one character per cycle while one of the two line buffers is free.
// Reset (rst_ni, async, low) clears all control state; line buffers are not cleared.
// Top level of the PEM base64 deframer; depends on pemdf_pkg and the pemdf_* modules.
module pem_certificate_base64_deframer #(
  parameter int LINE_MAX = pemdf_pkg::LINE_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // ch
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // data_byte
  output logic [1:0] m_axis_tuser,   // kind
  output logic       m_axis_tlast    // last
);

  localparam int ADDR_W = $clog2(2 * LINE_MAX);

  logic              we, re, push, full, q_valid, pop;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;
  pemdf_pkg::desc_t  desc, head;

  pemdf_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .push_o        (push),
    .desc_o        (desc),
    .full_i        (full)
  );

  pemdf_line_buf #(.LINE_MAX(LINE_MAX)) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pemdf_desc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  pemdf_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head),
    .q_pop_o       (pop),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
